// ===== rtl/core/sensor_reply_frame_checker_assert.svh =====
// Assertion macros used by the sensor reply frame checker top level.
`ifndef SENSOR_REPLY_FRAME_CHECKER_ASSERT_SVH
`define SENSOR_REPLY_FRAME_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define SRFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srfc: implication check failed");

// Next-cycle implication, checked outside reset.
`define SRFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srfc: next-cycle check failed");

`else

`define SRFC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SRFC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/srfc_pkg.sv =====
// Package: types, constants and the CRC-16 byte update for the reply frame checker.
`timescale 1ns / 1ps

package srfc_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int READING_W = 32;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 3;
  localparam int CRC_W     = 16;
  localparam int CFG_IDX_W = 2;

  // CRC-16, Modbus form (reflected)
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  // Frame positions
  localparam logic [POS_W-1:0] POS_FUNCTION = 3'd0;
  localparam logic [POS_W-1:0] POS_LENGTH   = 3'd1;
  localparam logic [POS_W-1:0] CRC_LEN      = 3'd6;
  localparam logic [POS_W-1:0] POS_CRC_LOW  = 3'd6;
  localparam logic [POS_W-1:0] POS_CRC_HIGH = 3'd7;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_FUNCTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_LENGTH   = 2'd1;
  localparam logic [BYTE_W-1:0]    RESET_FUNCTION        = 8'h03;
  localparam logic [BYTE_W-1:0]    RESET_LENGTH          = 8'h04;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_HEADER = 2'd1,
    STATUS_CRC    = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] expected_function;
    logic [BYTE_W-1:0] expected_length;
  } cfg_t;

  typedef struct packed {
    logic [READING_W-1:0] reading;
    status_t              status;
  } result_t;

  // One byte through the reflected CRC, eight bit steps unrolled
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] c_in,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/srfc_ifs.sv =====
// Interfaces: reply byte channel, result channel and configuration write channel.
`timescale 1ns / 1ps

interface srfc_in_if import srfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] reply_byte;
  logic              frame_start;

  modport source (output valid, reply_byte, frame_start, input ready);
  modport sink   (input valid, reply_byte, frame_start, output ready);
endinterface

interface srfc_out_if import srfc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [READING_W-1:0] reading;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, reading, status, input ready);
  modport sink   (input valid, reading, status, output ready);
endinterface

interface srfc_cfg_if import srfc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/srfc_cfg_regs.sv =====
// Configuration registers: expected function code and expected length byte.
`timescale 1ns / 1ps

module srfc_cfg_regs import srfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  srfc_cfg_if.sink   cfg,
  output cfg_t       cfg_values
);

  cfg_t regs;

  // Writes are always taken; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_function <= RESET_FUNCTION;
      regs.expected_length   <= RESET_LENGTH;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_EXPECTED_FUNCTION: regs.expected_function <= cfg.data;
        REG_EXPECTED_LENGTH:   regs.expected_length   <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cfg_values = regs;

endmodule

// ===== rtl/core/srfc_frame.sv =====
// Frame tracker: byte position, running CRC, header flag, payload and the frame verdict.
`timescale 1ns / 1ps

module srfc_frame import srfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,         // consume the presented byte this cycle
  input  logic [BYTE_W-1:0] reply_byte,
  input  logic              frame_start,
  input  cfg_t              cfg_values,
  output logic              frame_done,   // presented byte closes a frame
  output result_t           result
);

  logic [POS_W-1:0]     byte_position, byte_position_next;
  logic [CRC_W-1:0]     crc_register, crc_register_next;
  logic                 header_good, header_good_next;
  logic [READING_W-1:0] payload_shift, payload_shift_next;
  logic [BYTE_W-1:0]    crc_low_byte, crc_low_byte_next;

  logic [POS_W-1:0]     pos_eff;
  logic [CRC_W-1:0]     crc_eff;
  logic                 header_eff;
  logic [READING_W-1:0] payload_eff;
  logic [BYTE_W-1:0]    crc_low_eff;
  logic [CRC_W-1:0]     crc_updated;
  logic [CRC_W-1:0]     crc_received;

  // A start flag makes this byte the first of a fresh frame
  always_comb begin
    if (frame_start) begin
      pos_eff     = POS_FUNCTION;
      crc_eff     = CRC_INIT;
      header_eff  = 1'b1;
      payload_eff = '0;
      crc_low_eff = '0;
    end else begin
      pos_eff     = byte_position;
      crc_eff     = crc_register;
      header_eff  = header_good;
      payload_eff = payload_shift;
      crc_low_eff = crc_low_byte;
    end
  end

  assign crc_updated  = crc16_byte(crc_eff, reply_byte);
  assign crc_received = {reply_byte, crc_low_eff};
  assign frame_done   = (pos_eff == POS_CRC_HIGH);

  // Verdict: header mismatch wins over CRC mismatch; reading only when good
  always_comb begin
    result.reading = '0;
    if (!header_eff) begin
      result.status = STATUS_HEADER;
    end else if (crc_received != crc_eff) begin
      result.status = STATUS_CRC;
    end else begin
      result.status  = STATUS_OK;
      result.reading = payload_eff;
    end
  end

  // Next frame state
  always_comb begin
    byte_position_next = pos_eff + 3'd1;
    crc_register_next  = crc_eff;
    header_good_next   = header_eff;
    payload_shift_next = payload_eff;
    crc_low_byte_next  = crc_low_eff;

    if (pos_eff < CRC_LEN) begin
      crc_register_next = crc_updated;
    end

    if (pos_eff == POS_FUNCTION) begin
      header_good_next = header_eff & (reply_byte == cfg_values.expected_function);
    end else if (pos_eff == POS_LENGTH) begin
      header_good_next = header_eff & (reply_byte == cfg_values.expected_length);
    end else if (pos_eff < CRC_LEN) begin
      payload_shift_next = {payload_eff[READING_W-BYTE_W-1:0], reply_byte};
    end else if (pos_eff == POS_CRC_LOW) begin
      crc_low_byte_next = reply_byte;
    end else begin
      // Last byte: frame restarts
      byte_position_next = POS_FUNCTION;
      crc_register_next  = CRC_INIT;
      header_good_next   = 1'b1;
      payload_shift_next = '0;
      crc_low_byte_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_FUNCTION;
      crc_register  <= CRC_INIT;
      header_good   <= 1'b1;
      payload_shift <= '0;
      crc_low_byte  <= '0;
    end else if (step) begin
      byte_position <= byte_position_next;
      crc_register  <= crc_register_next;
      header_good   <= header_good_next;
      payload_shift <= payload_shift_next;
      crc_low_byte  <= crc_low_byte_next;
    end
  end

endmodule

// ===== rtl/core/sensor_reply_frame_checker.sv =====
// Top level of the sensor reply frame checker: input register, frame tracker, result register.
// Reply bytes enter one per clock through reply_in and are registered; from the input
// register the frame tracker updates position, header flag and CRC-16 (one unrolled
// byte step) and, on the eighth byte of a frame, loads one transaction into the
// result register: the four payload bytes (first one most significant) and a
// status of ok, header mismatch or CRC mismatch, with the reading forced to zero
// unless ok. A result reaches result_out through the input register and the result
// register. The sustained rate is one byte per cycle; reply_in only stalls when a
// frame-closing byte finds the result register still held by the sink. frame_start
// makes its byte the first of a new frame and drops any partial frame without a
// result. The user must write the two expected header values through cfg only while
// the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`include "sensor_reply_frame_checker_assert.svh"

module sensor_reply_frame_checker import srfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  srfc_in_if.sink     reply_in,
  srfc_out_if.source  result_out,
  srfc_cfg_if.sink    cfg
);

  cfg_t    cfg_values;
  result_t frame_result;
  logic    frame_done;

  logic              byte_valid;
  logic [BYTE_W-1:0] byte_data;
  logic              byte_start;
  logic              step;
  logic              result_load;

  logic                 out_valid;
  logic [READING_W-1:0] out_reading;
  status_t              out_status;
  logic                 out_failed;

  srfc_cfg_regs u_cfg_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cfg_values (cfg_values)
  );

  srfc_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .reply_byte  (byte_data),
    .frame_start (byte_start),
    .cfg_values  (cfg_values),
    .frame_done  (frame_done),
    .result      (frame_result)
  );

  // Held byte moves on unless it closes a frame and the result slot is busy
  assign step        = byte_valid && (!frame_done || !out_valid || result_out.ready);
  assign result_load = step && frame_done;
  assign reply_in.ready = !byte_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (reply_in.ready) begin
      byte_valid <= reply_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (reply_in.valid && reply_in.ready) begin
      byte_data  <= reply_in.reply_byte;
      byte_start <= reply_in.frame_start;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_reading <= frame_result.reading;
      out_status  <= frame_result.status;
    end
  end

  assign result_out.valid   = out_valid;
  assign result_out.reading = out_reading;
  assign result_out.status  = out_status;

  // Failed frame on show
  assign out_failed = out_valid && (out_status != STATUS_OK);

  // Checks
  `SRFC_ASSERT_IMPLY(a_load_into_free_slot, clk, rst, result_load, !out_valid || result_out.ready)
  `SRFC_ASSERT_IMPLY(a_no_overwrite_held_byte, clk, rst, byte_valid && !step, !reply_in.ready)
  `SRFC_ASSERT_IMPLY(a_failed_reading_zero, clk, rst, out_failed, out_reading == '0)
  `SRFC_ASSERT_NEXT(a_load_shows_result, clk, rst, result_load, out_valid)

endmodule
